/* src/cmsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsm_pkg
// Types and constants for the column move and stall monitor.
// ----------------------------------------------------------------------------
package cmsm_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_MOVING  = 3'd0,
        ST_REACHED = 3'd1,
        ST_TOP     = 3'd2,
        ST_STALL   = 3'd3,
        ST_ABORT   = 3'd4,
        ST_IDLE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_TOLERANCE  = 3'd0,
        REG_SPEED_FALL = 3'd1,
        REG_SPEED_RISE = 3'd2,
        REG_CONFIRM    = 3'd3,
        REG_GRACE      = 3'd4,
        REG_MIN_GAP    = 3'd5
    } reg_index_t;

    localparam logic [15:0] TOLERANCE_RST  = 16'd5;
    localparam logic [19:0] SPEED_FALL_RST = 20'd580;
    localparam logic [19:0] SPEED_RISE_RST = 20'd550;
    localparam logic [3:0]  CONFIRM_RST    = 4'd3;
    localparam logic [23:0] GRACE_RST      = 24'd50000;
    localparam logic [15:0] MIN_GAP_RST    = 16'd12;

    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [3:0]  SLOW_MAX  = 4'd15;

    typedef struct packed {
        logic               func;
        logic signed [31:0] position;
        logic signed [31:0] target;
        logic               top_hall;
        logic               abort_request;
        logic [19:0]        elapsed_us;
    } cmd_word_t;

    typedef struct packed {
        logic        raise_drive;
        logic        lower_drive;
        logic        encoder_reset;
        status_t     status;
        logic [31:0] distance_left;
    } res_word_t;

endpackage

/* src/column_move_stall_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_move_stall_monitor
// Bang-bang column move to a target count with top-limit stop, abort and stall check.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  cmd       in   cmd_valid/stall    cmd_word  (start or position sample)
//  res       out  res_valid/stall    res_word  (drives, status, distance)
//  cfg       in   APB psel/penable   paddr, pwdata, prdata
//
//  One word is taken per cycle while cmd_stall is low; its result passes
//  through the command register, then the result register.
//  The cmd register advances whenever the result register is empty or taken,
//  so cmd_stall rises only while a result is held by res_stall.
//  Reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module column_move_stall_monitor
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  cmsm_pkg::cmd_word_t         cmd_word,

    output logic                        res_valid,
    input  logic                        res_stall,
    output cmsm_pkg::res_word_t         res_word,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmsm_pkg::ADDR_W-1:0] paddr,
    input  logic [cmsm_pkg::DATA_W-1:0] pwdata,
    output logic [cmsm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // configuration
    logic [15:0] tolerance_reg;
    logic [19:0] speed_fall_reg;
    logic [19:0] speed_rise_reg;
    logic [3:0]  confirm_reg;
    logic [23:0] grace_reg;
    logic [15:0] min_gap_reg;

    logic                 cfg_wr;
    cmsm_pkg::reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cmsm_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg  <= cmsm_pkg::TOLERANCE_RST;
            speed_fall_reg <= cmsm_pkg::SPEED_FALL_RST;
            speed_rise_reg <= cmsm_pkg::SPEED_RISE_RST;
            confirm_reg    <= cmsm_pkg::CONFIRM_RST;
            grace_reg      <= cmsm_pkg::GRACE_RST;
            min_gap_reg    <= cmsm_pkg::MIN_GAP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                cmsm_pkg::REG_TOLERANCE:  tolerance_reg  <= pwdata[15:0];
                cmsm_pkg::REG_SPEED_FALL: speed_fall_reg <= pwdata[19:0];
                cmsm_pkg::REG_SPEED_RISE: speed_rise_reg <= pwdata[19:0];
                cmsm_pkg::REG_CONFIRM:    confirm_reg    <= pwdata[3:0];
                cmsm_pkg::REG_GRACE:      grace_reg      <= pwdata[23:0];
                cmsm_pkg::REG_MIN_GAP:    min_gap_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            cmsm_pkg::REG_TOLERANCE:  prdata = {16'd0, tolerance_reg};
            cmsm_pkg::REG_SPEED_FALL: prdata = {12'd0, speed_fall_reg};
            cmsm_pkg::REG_SPEED_RISE: prdata = {12'd0, speed_rise_reg};
            cmsm_pkg::REG_CONFIRM:    prdata = {28'd0, confirm_reg};
            cmsm_pkg::REG_GRACE:      prdata = {8'd0, grace_reg};
            cmsm_pkg::REG_MIN_GAP:    prdata = {16'd0, min_gap_reg};
            default:                  prdata = '0;
        endcase
    end

    // handshake
    logic                cmd_full_reg;
    cmsm_pkg::cmd_word_t cmd_hold_reg;
    logic                res_valid_reg;
    cmsm_pkg::res_word_t res_word_reg;
    cmsm_pkg::res_word_t res_word_next;
    logic                cmd_take;
    logic                adv;

    assign cmd_stall = cmd_full_reg && res_valid_reg && res_stall;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign adv       = cmd_full_reg && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_full_reg  <= cmd_take || (cmd_full_reg && !adv);
            res_valid_reg <= adv || (res_valid_reg && res_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_hold_reg <= cmd_word;
        end
        if (adv)
        begin
            res_word_reg <= res_word_next;
        end
    end

    // move state
    logic               moving_reg,      moving_next;
    logic               drive_down_reg,  drive_down_next;
    logic signed [31:0] last_pos_reg,    last_pos_next;
    logic signed [31:0] goal_pos_reg,    goal_pos_next;
    logic [23:0]        time_reg,        time_next;
    logic [3:0]         slow_count_reg,  slow_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg     <= 1'b0;
            drive_down_reg <= 1'b0;
            last_pos_reg   <= '0;
            goal_pos_reg   <= '0;
            time_reg       <= '0;
            slow_count_reg <= '0;
        end
        else if (adv)
        begin
            moving_reg     <= moving_next;
            drive_down_reg <= drive_down_next;
            last_pos_reg   <= last_pos_next;
            goal_pos_reg   <= goal_pos_next;
            time_reg       <= time_next;
            slow_count_reg <= slow_count_next;
        end
    end

    // datapath
    logic signed [31:0] goal_sel;
    logic [32:0]        gap_diff;
    logic [32:0]        gap_mag;
    logic [31:0]        dist_abs;
    logic               below_goal;
    logic [32:0]        dlt_diff;
    logic [32:0]        dlt_mag;
    logic               dlt_neg;
    logic               dlt_small;
    logic [40:0]        dlt_scaled;
    logic [19:0]        thr;
    logic [39:0]        thr_scaled;
    logic               slow;
    logic [24:0]        time_sum;
    logic [23:0]        time_sat;
    logic               stall_test;
    logic [3:0]         slow_inc;
    logic               in_tol;

    always_comb
    begin
        goal_sel   = (cmd_hold_reg.func == cmsm_pkg::FUNC_START) ?
                     cmd_hold_reg.target : goal_pos_reg;
        gap_diff   = {cmd_hold_reg.position[31], cmd_hold_reg.position}
                   - {goal_sel[31], goal_sel};
        gap_mag    = gap_diff[32] ? (~gap_diff + 33'd1) : gap_diff;
        dist_abs   = gap_mag[31:0];
        below_goal = gap_diff[32];
        in_tol     = dist_abs <= {16'd0, tolerance_reg};

        dlt_diff   = {cmd_hold_reg.position[31], cmd_hold_reg.position}
                   - {last_pos_reg[31], last_pos_reg};
        dlt_neg    = dlt_diff[32];
        dlt_mag    = dlt_neg ? (~dlt_diff + 33'd1) : dlt_diff;
        // beyond 21 bits the scaled step exceeds any threshold product
        dlt_small  = (dlt_mag[32:21] == 12'd0);
        dlt_scaled = {20'd0, dlt_mag[20:0]} * {21'd0, cmsm_pkg::US_PER_S};
        thr        = dlt_neg ? speed_fall_reg : speed_rise_reg;
        thr_scaled = {20'd0, thr} * {20'd0, cmd_hold_reg.elapsed_us};
        slow       = (cmd_hold_reg.elapsed_us == 20'd0) || (dlt_mag == 33'd0)
                   || (dlt_small && (dlt_scaled < {1'b0, thr_scaled}));

        time_sum   = {1'b0, time_reg} + {5'd0, cmd_hold_reg.elapsed_us};
        time_sat   = time_sum[24] ? 24'hFF_FFFF : time_sum[23:0];
        stall_test = (time_sat >= grace_reg) && (dist_abs > {16'd0, min_gap_reg}) && slow;
        slow_inc   = (slow_count_reg == cmsm_pkg::SLOW_MAX) ?
                     cmsm_pkg::SLOW_MAX : slow_count_reg + 4'd1;
    end

    always_comb
    begin
        moving_next     = moving_reg;
        drive_down_next = drive_down_reg;
        last_pos_next   = last_pos_reg;
        goal_pos_next   = goal_pos_reg;
        time_next       = time_reg;
        slow_count_next = slow_count_reg;

        res_word_next.raise_drive   = 1'b0;
        res_word_next.lower_drive   = 1'b0;
        res_word_next.encoder_reset = 1'b0;
        res_word_next.status        = cmsm_pkg::ST_IDLE;
        res_word_next.distance_left = dist_abs;

        if (cmd_hold_reg.func == cmsm_pkg::FUNC_START)
        begin
            goal_pos_next = cmd_hold_reg.target;
            if (below_goal && cmd_hold_reg.top_hall)
            begin
                moving_next                 = 1'b0;
                res_word_next.encoder_reset = 1'b1;
                res_word_next.status        = cmsm_pkg::ST_TOP;
            end
            else if (in_tol)
            begin
                moving_next          = 1'b0;
                res_word_next.status = cmsm_pkg::ST_REACHED;
            end
            else
            begin
                drive_down_next           = !below_goal;
                moving_next               = 1'b1;
                last_pos_next             = cmd_hold_reg.position;
                time_next                 = '0;
                slow_count_next           = '0;
                res_word_next.raise_drive = below_goal;
                res_word_next.lower_drive = !below_goal;
                res_word_next.status      = cmsm_pkg::ST_MOVING;
            end
        end
        else if (moving_reg)
        begin
            if (cmd_hold_reg.abort_request)
            begin
                moving_next          = 1'b0;
                res_word_next.status = cmsm_pkg::ST_ABORT;
            end
            else if (below_goal && cmd_hold_reg.top_hall)
            begin
                moving_next                 = 1'b0;
                res_word_next.encoder_reset = 1'b1;
                res_word_next.status        = cmsm_pkg::ST_TOP;
            end
            else
            begin
                time_next       = time_sat;
                slow_count_next = stall_test ? slow_inc : 4'd0;
                if (stall_test && (slow_inc >= confirm_reg))
                begin
                    moving_next          = 1'b0;
                    res_word_next.status = cmsm_pkg::ST_STALL;
                end
                else
                begin
                    last_pos_next = cmd_hold_reg.position;
                    if (in_tol)
                    begin
                        moving_next          = 1'b0;
                        res_word_next.status = cmsm_pkg::ST_REACHED;
                    end
                    else
                    begin
                        res_word_next.raise_drive = !drive_down_reg;
                        res_word_next.lower_drive = drive_down_reg;
                        res_word_next.status      = cmsm_pkg::ST_MOVING;
                    end
                end
            end
        end
    end

endmodule

/* src/cmsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsm_checker
// Port-level checks for the column move and stall monitor.
// ----------------------------------------------------------------------------
module cmsm_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input cmsm_pkg::res_word_t res_word
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.status != cmsm_pkg::ST_MOVING)
        |-> !res_word.raise_drive && !res_word.lower_drive)
        else $error("drive active on a stopped result");

    a_drive_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.status == cmsm_pkg::ST_MOVING)
        |-> (res_word.raise_drive != res_word.lower_drive) && !res_word.encoder_reset)
        else $error("moving result without exactly one drive");

    a_enc_reset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.encoder_reset |-> res_word.status == cmsm_pkg::ST_TOP)
        else $error("encoder reset without top limit");

endmodule

bind column_move_stall_monitor cmsm_checker u_cmsm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);

/* bench/column_move_stall_monitor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_move_stall_monitor_tb
// Self-checking bench: a directed table of start and sample words, then random
// move sequences under several register settings. Every result word is
// compared field by field with its table entry, if any, or a cycle-free model
// of the move and stall logic kept in the bench. Both channels see random idle
// bursts; the APB registers are written and read back between phases.
// ----------------------------------------------------------------------------
module column_move_stall_monitor_tb;

    typedef struct {
        cmsm_pkg::cmd_word_t w;
        bit                  typed;
        cmsm_pkg::res_word_t want;
    } plan_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_stall;
    cmsm_pkg::cmd_word_t           cmd_word  = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    cmsm_pkg::res_word_t           res_word;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [cmsm_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [cmsm_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [cmsm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // register shadows
    logic [15:0]         cfg_tolerance;
    logic [19:0]         cfg_fall;
    logic [19:0]         cfg_rise;
    logic [3:0]          cfg_confirm;
    logic [23:0]         cfg_grace;
    logic [15:0]         cfg_gap;

    // move state
    bit                  run_active;
    bit                  heading_down;
    logic signed [31:0]  prev_pos;
    logic signed [31:0]  goal_pos;
    logic [23:0]         run_time;
    logic [3:0]          slow_run;

    cmsm_pkg::res_word_t pending_results[$];
    plan_row_t           directed_plan[$];
    bit                  row_typed;
    cmsm_pkg::res_word_t row_want;
    bit                  quiet = 1'b0;
    bit                  long_gaps = 1'b0;
    int                  stall_left = 0;
    int                  mismatches = 0;

    column_move_stall_monitor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic cmsm_pkg::res_word_t outcome(input logic up, input logic dn,
                                                    input logic er,
                                                    input cmsm_pkg::status_t st,
                                                    input logic [31:0] d);
        cmsm_pkg::res_word_t r;
        r.raise_drive   = up;
        r.lower_drive   = dn;
        r.encoder_reset = er;
        r.status        = st;
        r.distance_left = d;
        return r;
    endfunction

    function automatic logic [31:0] abs_dist(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? 32'(-d) : 32'(d);
    endfunction

    function automatic cmsm_pkg::res_word_t column_step(input cmsm_pkg::cmd_word_t w);
        cmsm_pkg::res_word_t r;
        logic [31:0]         dist_left;
        logic [24:0]         tsum;
        longint              d;
        longint unsigned     mag;
        longint unsigned     lim;
        bit                  slow;
        r = '0;
        if (w.func == cmsm_pkg::FUNC_START)
        begin
            goal_pos = w.target;
            dist_left = abs_dist(w.position, w.target);
            if (w.position < w.target && w.top_hall)
            begin
                run_active = 1'b0;
                return outcome(1'b0, 1'b0, 1'b1, cmsm_pkg::ST_TOP, dist_left);
            end
            if (dist_left <= cfg_tolerance)
            begin
                run_active = 1'b0;
                return outcome(1'b0, 1'b0, 1'b0, cmsm_pkg::ST_REACHED, dist_left);
            end
            heading_down = w.position > w.target;
            run_active   = 1'b1;
            prev_pos     = w.position;
            run_time     = '0;
            slow_run     = '0;
            return outcome(!heading_down, heading_down, 1'b0, cmsm_pkg::ST_MOVING, dist_left);
        end
        dist_left = abs_dist(w.position, goal_pos);
        if (!run_active)
            return outcome(1'b0, 1'b0, 1'b0, cmsm_pkg::ST_IDLE, dist_left);
        if (w.abort_request)
        begin
            run_active = 1'b0;
            return outcome(1'b0, 1'b0, 1'b0, cmsm_pkg::ST_ABORT, dist_left);
        end
        if (w.position < goal_pos && w.top_hall)
        begin
            run_active = 1'b0;
            return outcome(1'b0, 1'b0, 1'b1, cmsm_pkg::ST_TOP, dist_left);
        end
        tsum = {1'b0, run_time} + 25'(w.elapsed_us);
        run_time = tsum[24] ? 24'hFF_FFFF : tsum[23:0];
        d = longint'(w.position) - longint'(prev_pos);
        if (w.elapsed_us == 0 || d == 0)
        begin
            slow = 1'b1;
        end
        else
        begin
            mag  = longint'(d < 0 ? -d : d) * longint'(cmsm_pkg::US_PER_S);
            lim  = longint'(d < 0 ? cfg_fall : cfg_rise) * longint'(w.elapsed_us);
            slow = mag < lim;
        end
        if (run_time >= cfg_grace && dist_left > cfg_gap && slow)
        begin
            if (slow_run < cmsm_pkg::SLOW_MAX)
                slow_run++;
            if (slow_run >= cfg_confirm)
            begin
                run_active = 1'b0;
                return outcome(1'b0, 1'b0, 1'b0, cmsm_pkg::ST_STALL, dist_left);
            end
        end
        else
        begin
            slow_run = '0;
        end
        prev_pos = w.position;
        if (dist_left <= cfg_tolerance)
        begin
            run_active = 1'b0;
            return outcome(1'b0, 1'b0, 1'b0, cmsm_pkg::ST_REACHED, dist_left);
        end
        return outcome(!heading_down, heading_down, 1'b0, cmsm_pkg::ST_MOVING, dist_left);
    endfunction

    // sample at the falling edge: values hold until the accepting rising edge
    always @(negedge clk)
    begin : watch
        cmsm_pkg::res_word_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    note_mismatch("result word with nothing pending");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_word.raise_drive !== want.raise_drive)
                        note_mismatch($sformatf("raise_drive %b, want %b",
                                                res_word.raise_drive, want.raise_drive));
                    if (res_word.lower_drive !== want.lower_drive)
                        note_mismatch($sformatf("lower_drive %b, want %b",
                                                res_word.lower_drive, want.lower_drive));
                    if (res_word.encoder_reset !== want.encoder_reset)
                        note_mismatch($sformatf("encoder_reset %b, want %b",
                                                res_word.encoder_reset, want.encoder_reset));
                    if (res_word.status !== want.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                res_word.status, want.status));
                    if (res_word.distance_left !== want.distance_left)
                        note_mismatch($sformatf("distance_left %h, want %h",
                                                res_word.distance_left, want.distance_left));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                want = column_step(cmd_word);
                if (row_typed)
                    want = row_want;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet)
        begin
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input cmsm_pkg::cmd_word_t w, input bit typed,
                             input cmsm_pkg::res_word_t want);
        bit taken;
        taken = 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        row_typed = typed;
        row_want  = want;
        while (!taken)
        begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cmsm_pkg::reg_index_t idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cmsm_pkg::REG_TOLERANCE:
            begin
                mask = 32'h0000_FFFF;
                cfg_tolerance = val[15:0];
            end
            cmsm_pkg::REG_SPEED_FALL:
            begin
                mask = 32'h000F_FFFF;
                cfg_fall = val[19:0];
            end
            cmsm_pkg::REG_SPEED_RISE:
            begin
                mask = 32'h000F_FFFF;
                cfg_rise = val[19:0];
            end
            cmsm_pkg::REG_CONFIRM:
            begin
                mask = 32'h0000_000F;
                cfg_confirm = val[3:0];
            end
            cmsm_pkg::REG_GRACE:
            begin
                mask = 32'h00FF_FFFF;
                cfg_grace = val[23:0];
            end
            default:
            begin
                mask = 32'h0000_FFFF;
                cfg_gap = val[15:0];
            end
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        back = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== (val & mask))
            note_mismatch($sformatf("register %0d reads %h, want %h", idx, back, val & mask));
    endtask

    task automatic set_registers(input logic [31:0] tol, input logic [31:0] fall,
                                 input logic [31:0] rise, input logic [31:0] conf,
                                 input logic [31:0] grace, input logic [31:0] gap);
        cfg_write(cmsm_pkg::REG_TOLERANCE, tol);
        cfg_write(cmsm_pkg::REG_SPEED_FALL, fall);
        cfg_write(cmsm_pkg::REG_SPEED_RISE, rise);
        cfg_write(cmsm_pkg::REG_CONFIRM, conf);
        cfg_write(cmsm_pkg::REG_GRACE, grace);
        cfg_write(cmsm_pkg::REG_MIN_GAP, gap);
    endtask

    task automatic add_row(input logic f, input logic [31:0] p, input logic [31:0] t,
                           input logic h, input logic a, input logic [19:0] e,
                           input bit typed, input cmsm_pkg::res_word_t want);
        plan_row_t row;
        row.w.func          = f;
        row.w.position      = p;
        row.w.target        = t;
        row.w.top_hall      = h;
        row.w.abort_request = a;
        row.w.elapsed_us    = e;
        row.typed           = typed;
        row.want            = want;
        directed_plan.push_back(row);
    endtask

    // move sequences: a start word, then samples closing in at speeds from standstill
    // to well above the stall threshold; some plain noise words in between
    task automatic run_sequences(input int n_items);
        int                  sent;
        int                  nsamp;
        longint              tgt;
        longint              pos;
        longint              off;
        longint              step;
        longint              nominal;
        longint              remain;
        int unsigned         el;
        int unsigned         thr;
        bit                  down;
        cmsm_pkg::cmd_word_t w;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                w.func          = $urandom_range(0, 1);
                w.position      = $urandom;
                w.target        = $urandom;
                w.top_hall      = $urandom_range(0, 1);
                w.abort_request = $urandom_range(0, 1);
                w.elapsed_us    = $urandom_range(0, 20'hF_FFFF);
                send_word(w, 1'b0, '0);
                sent++;
                continue;
            end
            if ($urandom_range(0, 3) == 0)
                tgt = longint'(int'($urandom));
            else
                tgt = longint'($urandom_range(0, 20000)) - 10000;
            case ($urandom_range(0, 9))
                0:       off = $urandom_range(0, cfg_tolerance);
                1:       off = $urandom & 32'h7FFF_FFFF;
                2:       off = cfg_tolerance + $urandom_range(1, 50);
                default: off = cfg_tolerance + cfg_gap
                               + longint'($urandom_range(1, 20000)) * (long_gaps ? 500 : 1);
            endcase
            pos = $urandom_range(0, 1) ? tgt + off : tgt - off;
            pos = longint'(int'(pos[31:0]));
            w.func          = cmsm_pkg::FUNC_START;
            w.position      = pos[31:0];
            w.target        = tgt[31:0];
            w.top_hall      = ($urandom_range(0, 7) == 0);
            w.abort_request = $urandom_range(0, 1);
            w.elapsed_us    = $urandom_range(0, 20'hF_FFFF);
            send_word(w, 1'b0, '0);
            sent++;
            nsamp = $urandom_range(1, long_gaps ? 24 : 14);
            for (int k = 0; k < nsamp; k++)
            begin
                down = pos > tgt;
                case ($urandom_range(0, 9))
                    0:       el = 0;
                    1:       el = 20'hF_FFFF;
                    default: el = long_gaps ? $urandom_range(200000, 20'hF_FFFF)
                                            : $urandom_range(1, 30000);
                endcase
                thr = down ? cfg_fall : cfg_rise;
                nominal = longint'(thr) * el / 1000000;
                case ($urandom_range(0, 7))
                    0:       step = 0;
                    1, 2:    step = nominal + $urandom_range(0, 2) - 1;
                    default: step = nominal * $urandom_range(2, 30) + $urandom_range(1, 200);
                endcase
                remain = down ? pos - tgt : tgt - pos;
                if ($urandom_range(0, 9) == 0)
                    step = -step;
                else if (step >= remain)
                    step = remain + $urandom_range(0, 8) - 4;
                pos = down ? pos - step : pos + step;
                pos = longint'(int'(pos[31:0]));
                w.func          = cmsm_pkg::FUNC_SAMPLE;
                w.position      = pos[31:0];
                w.target        = $urandom;
                w.top_hall      = ($urandom_range(0, 19) == 0);
                w.abort_request = ($urandom_range(0, 29) == 0);
                w.elapsed_us    = el[19:0];
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("[column_move_stall_monitor] ERROR");
        $finish;
    end

    initial
    begin
        cfg_tolerance = cmsm_pkg::TOLERANCE_RST;
        cfg_fall      = cmsm_pkg::SPEED_FALL_RST;
        cfg_rise      = cmsm_pkg::SPEED_RISE_RST;
        cfg_confirm   = cmsm_pkg::CONFIRM_RST;
        cfg_grace     = cmsm_pkg::GRACE_RST;
        cfg_gap       = cmsm_pkg::MIN_GAP_RST;
        run_active    = 1'b0;
        heading_down  = 1'b0;
        prev_pos      = '0;
        goal_pos      = '0;
        run_time      = '0;
        slow_run      = '0;
        row_typed     = 1'b0;
        row_want      = '0;

        // idle samples, start outcomes, extremes, abort, top limit, stall
        add_row(cmsm_pkg::FUNC_SAMPLE, 100, 0, 0, 0, 0, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_IDLE, 100));
        add_row(cmsm_pkg::FUNC_SAMPLE, 32'h8000_0000, 0, 0, 0, 0, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_IDLE, 32'h8000_0000));
        add_row(cmsm_pkg::FUNC_START, 0, 1000, 1, 0, 0, 1,
                outcome(0, 0, 1, cmsm_pkg::ST_TOP, 1000));
        add_row(cmsm_pkg::FUNC_START, 1000, 1003, 0, 0, 0, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_REACHED, 3));
        add_row(cmsm_pkg::FUNC_START, 1003, 1003, 1, 0, 0, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_REACHED, 0));
        add_row(cmsm_pkg::FUNC_START, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 20'hF_FFFF, 1,
                outcome(1, 0, 0, cmsm_pkg::ST_MOVING, 32'hFFFF_FFFF));
        add_row(cmsm_pkg::FUNC_SAMPLE, 32'h8000_000A, 0, 0, 1, 100, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_ABORT, 32'hFFFF_FFF5));
        add_row(cmsm_pkg::FUNC_START, 5000, 0, 1, 0, 0, 1,
                outcome(0, 1, 0, cmsm_pkg::ST_MOVING, 5000));
        add_row(cmsm_pkg::FUNC_SAMPLE, 4000, 32'hFFFF_FFFF, 1, 0, 1000, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 4000, 0, 0, 0, 20'hF_FFFF, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 4000, 0, 0, 0, 0, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 3999, 0, 0, 0, 1000000, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 3000, 0, 0, 0, 10, 1,
                outcome(0, 0, 0, cmsm_pkg::ST_IDLE, 3000));
        add_row(cmsm_pkg::FUNC_START, 0, 10000, 0, 1, 0, 1,
                outcome(1, 0, 0, cmsm_pkg::ST_MOVING, 10000));
        add_row(cmsm_pkg::FUNC_SAMPLE, 500, 0, 1, 0, 10, 1,
                outcome(0, 0, 1, cmsm_pkg::ST_TOP, 9500));
        add_row(cmsm_pkg::FUNC_START, 0, 100, 0, 0, 0, 1,
                outcome(1, 0, 0, cmsm_pkg::ST_MOVING, 100));
        add_row(cmsm_pkg::FUNC_SAMPLE, 96, 0, 0, 0, 10, 0, '0);
        add_row(cmsm_pkg::FUNC_START, 0, 1000000, 0, 0, 0, 1,
                outcome(1, 0, 0, cmsm_pkg::ST_MOVING, 1000000));
        add_row(cmsm_pkg::FUNC_SAMPLE, 100000, 0, 0, 0, 60000, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 100000, 0, 0, 0, 20'hF_FFFF, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 100001, 0, 0, 0, 1, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 2000000, 0, 0, 0, 5, 0, '0);
        add_row(cmsm_pkg::FUNC_SAMPLE, 1000003, 0, 0, 0, 5, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send_word(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].want);
        run_sequences(130);
        drain();

        set_registers(0, 0, 0, 0, 0, 0);
        run_sequences(120);
        drain();

        long_gaps = 1'b1;
        set_registers(32'hFFFF, 32'hF_FFFF, 32'hF_FFFF, 32'hF, 32'hFF_FFFF, 32'hFFFF);
        run_sequences(130);
        drain();

        long_gaps = 1'b0;
        set_registers($urandom_range(0, 50), $urandom_range(100, 5000),
                      $urandom_range(100, 5000), $urandom_range(1, 5),
                      $urandom_range(0, 100000), $urandom_range(0, 100));
        run_sequences(130);
        drain();

        set_registers(32'(cmsm_pkg::TOLERANCE_RST), 32'(cmsm_pkg::SPEED_FALL_RST),
                      32'(cmsm_pkg::SPEED_RISE_RST), $urandom_range(1, 15),
                      $urandom_range(0, 60000), 32'(cmsm_pkg::MIN_GAP_RST));
        run_sequences(60);
        quiet = 1'b1;
        run_sequences(80);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[column_move_stall_monitor] OK");
        else
            $display("[column_move_stall_monitor] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/cmsm_pkg.sv
src/column_move_stall_monitor.sv
src/cmsm_checker.sv
bench/column_move_stall_monitor_tb.sv
